/* rtl/array_list_insert_delete_macros.svh */
// Assertion macros shared by the array list RTL.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef ARRAY_LIST_INSERT_DELETE_MACROS_SVH
`define ARRAY_LIST_INSERT_DELETE_MACROS_SVH

// same-cycle implication
`define ALI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ALI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ali_pkg.sv */
`timescale 1ns / 1ps
// Types and codes for the array list insert/delete block.
// No dependencies; imported by every module of the block.
package ali_pkg;

	localparam int DATA_W  = 32;
	localparam int POS_W   = 8;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [STAT_W-1:0] stat_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_DELETE = 2'd1;
	localparam cmd_t CMD_READ   = 2'd2;

	localparam stat_t ST_OK    = 2'd0;
	localparam stat_t ST_FULL  = 2'd1;
	localparam stat_t ST_EMPTY = 2'd2;
	localparam stat_t ST_RANGE = 2'd3;

	// broadcast to every cell, already qualified by the input transfer
	typedef struct packed {
		logic ins;
		logic del;
		logic rd;
		logic acc;
		pos_t pos;
	} cell_ctl_t;

endpackage

/* rtl/array_list_insert_delete.sv */
`timescale 1ns / 1ps
// Packed insertion list held in a row of shifting cells; uses ali_pkg, ali_cell, ali_rd_tree.
// Result registers after an input transfer: cell capture, group OR, output.
// Throughput: one item per cycle while out_ready is high; inserts/deletes shift cells at or above
// the position in the cycle of the transfer; the read path is a three-stage pipeline behind them.
// Reset: occupancy and pipeline valids clear at once; cell contents stay undefined until written.
module array_list_insert_delete import ali_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [CMD_W-1:0]          cmd,
	input  logic [POS_W-1:0]          position,
	input  logic signed [DATA_W-1:0]  value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [STAT_W-1:0]         status,
	output logic signed [DATA_W-1:0]  read_value,
	output logic [COUNT_W-1:0]        count
);

`include "array_list_insert_delete_macros.svh"

	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int EXT_W = POS_W + 1;

	logic [OCC_W-1:0]   occ_q, occ_d;
	logic [EXT_W-1:0]   pos_x, occ_x;
	logic               full, empty, accept;
	logic               op_ins, op_del, op_rd;
	stat_t              stat_d;
	pos_t               ins_pos;
	cell_ctl_t          ctl;
	data_t [DEPTH-1:0]  cell_data;
	data_t [DEPTH-1:0]  cell_rd_s1;
	data_t              tree_rd;

	logic               v_s1, v_s2;
	stat_t              status_s1, status_s2;
	logic [COUNT_W-1:0] count_s1, count_s2;
	logic               adv1, adv2, adv_out;

	assign full   = (occ_q == OCC_W'(DEPTH));
	assign empty  = (occ_q == '0);
	assign pos_x  = EXT_W'(position);
	assign occ_x  = EXT_W'(occ_q);
	// insert past the end appends
	assign ins_pos = (pos_x > occ_x) ? occ_x[POS_W-1:0] : position;

	assign adv_out  = !out_valid || out_ready;
	assign adv2     = !v_s2 || adv_out;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;
	assign accept   = in_valid && in_ready;

	always_comb begin
		stat_d = ST_OK;
		occ_d  = occ_q;
		op_ins = 1'b0;
		op_del = 1'b0;
		op_rd  = 1'b0;
		case (cmd)
			CMD_INSERT: begin
				if (full) begin
					stat_d = ST_FULL;
				end else begin
					op_ins = 1'b1;
					occ_d  = occ_q + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (empty) begin
					stat_d = ST_EMPTY;
				end else begin
					op_del = 1'b1;
					occ_d  = occ_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (pos_x >= occ_x) begin
					stat_d = ST_RANGE;
				end else begin
					op_rd = 1'b1;
				end
			end
			default: begin
				stat_d = ST_OK;
			end
		endcase
	end

	// delete needs no clamp: slots at or above the new count are dead anyway
	always_comb begin
		ctl.acc = accept;
		ctl.ins = accept && op_ins;
		ctl.del = accept && op_del;
		ctl.rd  = accept && op_rd;
		ctl.pos = op_ins ? ins_pos : position;
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		data_t left, right;
		if (k == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_data[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = cell_data[k+1];
		end
		ali_cell #(
			.IDX(k)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.value ($unsigned(value)),
			.left  (left),
			.right (right),
			.data  (cell_data[k]),
			.rd_s1 (cell_rd_s1[k])
		);
	end

	ali_rd_tree #(
		.DEPTH(DEPTH)
	) u_rd_tree (
		.clk   (clk),
		.load  (adv2 && v_s1),
		.lanes (cell_rd_s1),
		.rd    (tree_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				occ_q <= occ_d;
			end
			if (adv1) begin
				v_s1 <= accept;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_valid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= stat_d;
			count_s1  <= COUNT_W'(occ_d);
		end
		if (adv2 && v_s1) begin
			status_s2 <= status_s1;
			count_s2  <= count_s1;
		end
		if (adv_out && v_s2) begin
			status     <= status_s2;
			count      <= count_s2;
			read_value <= $signed(tree_rd);
		end
	end

	`ALI_ASSERT_NOW(a_occ_bound, 1'b1, occ_q <= OCC_W'(DEPTH), "occupancy beyond depth")
	`ALI_ASSERT_NEXT(a_ins_grow, accept && (cmd == CMD_INSERT) && !full,
		occ_q == OCC_W'($past(occ_q) + 1'b1), "insert did not grow the list")
	`ALI_ASSERT_NOW(a_rd_status, out_valid && (read_value != '0), status == ST_OK,
		"read data on a failed result")
	`ALI_ASSERT_NEXT(a_s2_hold, v_s2 && !adv2, v_s2, "stage two dropped an item")

endmodule

/* rtl/ali_cell.sv */
`timescale 1ns / 1ps
// One list cell: holds an entry, shifts to/from its neighbours, captures reads.
// Depends on ali_pkg.
module ali_cell import ali_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  data_t     value,
	input  data_t     left,
	input  data_t     right,
	output data_t     data,
	output data_t     rd_s1
);

	localparam pos_t MY_IDX = pos_t'(IDX);

	data_t data_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && (MY_IDX > ctl.pos)) begin
			data_q <= left;
		end else if (ctl.ins && (MY_IDX == ctl.pos)) begin
			data_q <= value;
		end else if (ctl.del && (MY_IDX >= ctl.pos)) begin
			data_q <= right;
		end
	end

	// gated so the read tree can simply OR every lane
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			rd_s1 <= (ctl.rd && (MY_IDX == ctl.pos)) ? data_q : '0;
		end
	end

	assign data = data_q;

endmodule

/* rtl/ali_rd_tree.sv */
`timescale 1ns / 1ps
// Registered OR tree gathering the one live read lane from the cell row.
// Depends on ali_pkg; each group of eight lanes is ORed and registered, then the groups are ORed.
module ali_rd_tree import ali_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              load,
	input  data_t [DEPTH-1:0] lanes,
	output data_t             rd
);

	localparam int GRP   = 8;
	localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
	localparam int LANES = NGRP * GRP;

	data_t [LANES-1:0] pad;
	data_t [NGRP-1:0]  grp_d;
	data_t [NGRP-1:0]  grp_s2;

	assign pad = (LANES * DATA_W)'(lanes);

	always_comb begin
		grp_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			for (int j = 0; j < GRP; j++) begin
				grp_d[g] = grp_d[g] | pad[g*GRP + j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s2 <= grp_d;
		end
	end

	always_comb begin
		rd = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd = rd | grp_s2[g];
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for array_list_insert_delete: directed table then random phases of list traffic.
// Depends on ali_pkg and the block's RTL; checks results against table values or a behavioural list model.
module tb;
	import ali_pkg::*;

	localparam int DEPTH = 64;
	localparam int RAND_ITEMS = 1750;
	localparam cmd_t CMD_NOP = 2'd3; // unused code, must act as a no-op

	typedef struct packed {
		stat_t                st;
		data_t                rd;
		logic [COUNT_W-1:0]   cnt;
	} list_rsp_t;

	typedef struct packed {
		cmd_t       c;
		pos_t       p;
		data_t      v;
		logic       chk;
		list_rsp_t  want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	cmd_t cmd;
	pos_t position;
	logic signed [DATA_W-1:0] value;
	logic out_valid;
	logic out_ready;
	logic [STAT_W-1:0] status;
	logic signed [DATA_W-1:0] read_value;
	logic [COUNT_W-1:0] count;

	// behavioural list state
	data_t list_cells [0:DEPTH-1];
	int list_len;

	list_rsp_t rsp_due [$];
	dir_row_t dir_rows [$];
	list_rsp_t want_rsp;
	bit quiet;
	int mismatches;
	int n_ins, n_del, n_rd, n_nop, n_full, n_empty, n_range;

	array_list_insert_delete #(.DEPTH(DEPTH)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic list_rsp_t list_apply(cmd_t c, pos_t p, data_t v);
		int k;
		int at;
		list_rsp_t r;
		r.st = ST_OK;
		r.rd = '0;
		at = int'(p);
		case (c)
			CMD_INSERT: begin
				if (list_len >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					if (at > list_len)
						at = list_len;
					for (k = list_len; k > at; k--)
						list_cells[k] = list_cells[k-1];
					list_cells[at] = v;
					list_len++;
				end
			end
			CMD_DELETE: begin
				if (list_len == 0) begin
					r.st = ST_EMPTY;
				end else begin
					if (at > list_len - 1)
						at = list_len - 1;
					for (k = at; k + 1 < list_len; k++)
						list_cells[k] = list_cells[k+1];
					list_len--;
				end
			end
			CMD_READ: begin
				if (at >= list_len)
					r.st = ST_RANGE;
				else
					r.rd = list_cells[at];
			end
			default: ;
		endcase
		r.cnt = list_len[COUNT_W-1:0];
		return r;
	endfunction

	task automatic add_row(cmd_t c, pos_t p, data_t v, logic chk, stat_t st, data_t rd,
			logic [COUNT_W-1:0] cnt);
		dir_row_t row;
		row.c = c;
		row.p = p;
		row.v = v;
		row.chk = chk;
		row.want.st = st;
		row.want.rd = rd;
		row.want.cnt = cnt;
		dir_rows.push_back(row);
	endtask

	// one input transfer; the expectation is queued at the accepting edge
	task automatic push_item(cmd_t c, pos_t p, data_t v, logic chk, list_rsp_t typed);
		int gap;
		list_rsp_t pred;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		position <= p;
		value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = list_apply(c, p, v);
		case (c)
			CMD_INSERT: n_ins++;
			CMD_DELETE: n_del++;
			CMD_READ:   n_rd++;
			default:    n_nop++;
		endcase
		if (pred.st == ST_FULL) n_full++;
		if (pred.st == ST_EMPTY) n_empty++;
		if (pred.st == ST_RANGE) n_range++;
		rsp_due.push_back(chk ? typed : pred);
	endtask

	task automatic report_mismatch(string what, list_rsp_t want);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: want st=%0d rd=%h cnt=%0d, got st=%0d rd=%h cnt=%0d", $time,
				what, want.st, want.rd, want.cnt, status, read_value, count);
	endtask

	// output side: check every result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (rsp_due.size() == 0) begin
				report_mismatch("result with nothing pending", '0);
			end else begin
				want_rsp = rsp_due.pop_front();
				if (status !== want_rsp.st || read_value !== want_rsp.rd
						|| count !== want_rsp.cnt)
					report_mismatch("result mismatch", want_rsp);
			end
		end
	end

	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		#2_000_000;
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		int i, j, n_rand, plen, mode, r, s, limit;
		cmd_t c;
		pos_t p;
		data_t v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_INSERT;
		position = '0;
		value = '0;
		quiet = 1'b0;
		mismatches = 0;
		list_len = 0;
		n_ins = 0; n_del = 0; n_rd = 0; n_nop = 0;
		n_full = 0; n_empty = 0; n_range = 0;
		for (i = 0; i < DEPTH; i++)
			list_cells[i] = '0;

		// empty list, append past the end, extremes, clamped deletes
		add_row(CMD_READ,   8'd0,   32'h0,        1, ST_RANGE, 32'h0,        7'd0);
		add_row(CMD_DELETE, 8'd0,   32'h0,        1, ST_EMPTY, 32'h0,        7'd0);
		add_row(CMD_DELETE, 8'd255, 32'hFFFFFFFF, 1, ST_EMPTY, 32'h0,        7'd0);
		add_row(CMD_NOP,    8'd255, 32'hFFFFFFFF, 1, ST_OK,    32'h0,        7'd0);
		add_row(CMD_INSERT, 8'd255, 32'h7FFFFFFF, 1, ST_OK,    32'h0,        7'd1);
		add_row(CMD_INSERT, 8'd0,   32'h80000000, 1, ST_OK,    32'h0,        7'd2);
		add_row(CMD_READ,   8'd0,   32'h0,        1, ST_OK,    32'h80000000, 7'd2);
		add_row(CMD_READ,   8'd1,   32'h0,        1, ST_OK,    32'h7FFFFFFF, 7'd2);
		add_row(CMD_READ,   8'd2,   32'h0,        1, ST_RANGE, 32'h0,        7'd2);
		add_row(CMD_READ,   8'd255, 32'hFFFFFFFF, 1, ST_RANGE, 32'h0,        7'd2);
		add_row(CMD_INSERT, 8'd1,   32'hFFFFFFFF, 1, ST_OK,    32'h0,        7'd3);
		add_row(CMD_INSERT, 8'd200, 32'h0,        1, ST_OK,    32'h0,        7'd4);
		add_row(CMD_READ,   8'd1,   32'h0,        1, ST_OK,    32'hFFFFFFFF, 7'd4);
		add_row(CMD_DELETE, 8'd255, 32'h0,        1, ST_OK,    32'h0,        7'd3);
		add_row(CMD_READ,   8'd2,   32'h0,        1, ST_OK,    32'h7FFFFFFF, 7'd3);
		add_row(CMD_DELETE, 8'd0,   32'h0,        1, ST_OK,    32'h0,        7'd2);
		add_row(CMD_READ,   8'd0,   32'h0,        1, ST_OK,    32'hFFFFFFFF, 7'd2);
		add_row(CMD_NOP,    8'd0,   32'h12345678, 1, ST_OK,    32'h0,        7'd2);
		add_row(CMD_INSERT, 8'd2,   32'hA5A5A5A5, 0, ST_OK,    32'h0,        7'd0);
		add_row(CMD_READ,   8'd1,   32'h0,        0, ST_OK,    32'h0,        7'd0);
		add_row(CMD_DELETE, 8'd1,   32'h0,        0, ST_OK,    32'h0,        7'd0);
		add_row(CMD_DELETE, 8'd0,   32'h0,        0, ST_OK,    32'h0,        7'd0);
		add_row(CMD_DELETE, 8'd0,   32'h0,        0, ST_OK,    32'h0,        7'd0);
		add_row(CMD_DELETE, 8'd0,   32'h0,        1, ST_EMPTY, 32'h0,        7'd0);
		add_row(CMD_READ,   8'd0,   32'h0,        1, ST_RANGE, 32'h0,        7'd0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			push_item(dir_rows[i].c, dir_rows[i].p, dir_rows[i].v, dir_rows[i].chk,
				dir_rows[i].want);

		// phases biased to grow, drain, mix or read, so full and empty are hit repeatedly
		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			mode = $urandom_range(0, 3);
			quiet = ($urandom_range(0, 3) == 0);
			plen = $urandom_range(40, 120);
			for (j = 0; j < plen; j++) begin
				r = $urandom_range(0, 99);
				case (mode)
					0: limit = 75;
					1: limit = 20;
					2: limit = 40;
					default: limit = 20;
				endcase
				if (r < 3)
					c = CMD_NOP;
				else if (r < limit)
					c = CMD_INSERT;
				else if (r < (mode == 0 ? 88 : mode == 1 ? 80 : mode == 2 ? 70 : 35))
					c = CMD_DELETE;
				else
					c = CMD_READ;
				s = $urandom_range(0, 9);
				case (s)
					0, 1, 2, 3: p = pos_t'($urandom_range(0, list_len));
					4: p = pos_t'(list_len);
					5: p = '0;
					6: p = (list_len > 0) ? pos_t'(list_len - 1) : '0;
					7, 8: p = pos_t'($urandom_range(0, 255));
					default: p = 8'd255;
				endcase
				s = $urandom_range(0, 9);
				case (s)
					0: v = 32'h7FFFFFFF;
					1: v = 32'h80000000;
					2: v = 32'h0;
					3: v = 32'hFFFFFFFF;
					default: v = $urandom;
				endcase
				push_item(c, p, v, 1'b0, '0);
				n_rand++;
			end
		end
		in_valid <= 1'b0;
		quiet = 1'b0;

		while (rsp_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d items: %0d inserts, %0d deletes, %0d reads, %0d no-ops",
			dir_rows.size() + n_rand, n_ins, n_del, n_rd, n_nop);
		$display("rejected: %0d full, %0d empty, %0d reads out of range; %0d mismatches",
			n_full, n_empty, n_range, mismatches);
		if (mismatches == 0 && rsp_due.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
